// File: src/asa_pkg.sv
// Shared types and constants for the aligned stack allocator.
// No dependencies; imported by every module of the block except asa_ram.
package asa_pkg;

  localparam int MAX_CAPACITY = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int HEADER_ALIGN = 8;
  localparam int MAX_ALIGN    = 4096;

  localparam int OFF_W   = 17;  // offsets, sizes, top
  localparam int CNT_W   = 13;  // live count, marker count
  localparam int ALIGN_W = 13;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;

  // one header entry per header granule of the buffer
  localparam int STORE_DEPTH = MAX_CAPACITY / HEADER_ALIGN;
  localparam int GRAN_W      = $clog2(STORE_DEPTH);
  localparam int HDR_SHIFT   = $clog2(HEADER_ALIGN);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_CAPACITY = 1'b0;  // paddr MSB value that selects capacity_bytes
  localparam logic [OFF_W-1:0] CAPACITY_RESET = OFF_W'(MAX_CAPACITY);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC     = 3'd0,
    REQ_FREE      = 3'd1,
    REQ_RESET     = 3'd2,
    REQ_MARKER    = 3'd3,
    REQ_FREE_MARK = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_BAD_PTR = 2'd2,
    STAT_AHEAD   = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } fsm_t;

endpackage

// File: src/aligned_stack_allocator.sv
// Aligned stack allocator: top-of-stack offset, live count, header store in RAM.
// Results: allocate, reset, read marker, free to marker, bad requests and frees
//   that fail the range check give their result the cycle after acceptance;
//   a free that reads its header first issues a RAM read, then updates in S_READ.
// Throughput: 1 request/cycle unless out_stall holds the result or a free reads a header.
// Reset: top and count clear, capacity = 65536; header RAM is not cleared.
module aligned_stack_allocator
  import asa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [OFF_W-1:0]      in_alloc_size,
  input  logic [ALIGN_W-1:0]    in_alloc_alignment,
  input  logic [OFF_W-1:0]      in_user_offset,
  input  logic [OFF_W-1:0]      in_marker_top,
  input  logic [CNT_W-1:0]      in_marker_count,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [OFF_W-1:0]      out_block_offset,
  output logic [OFF_W-1:0]      out_top_offset,
  output logic [CNT_W-1:0]      out_live_count,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_t             state_r, state_nxt;
  logic [OFF_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register: parts the request side from a stalled consumer
  logic              out_valid_r, out_valid_nxt;
  stat_t             out_status_r, out_status_nxt;
  logic [OFF_W-1:0]  out_block_r, out_block_nxt;
  logic [OFF_W-1:0]  out_top_r, out_top_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [OFF_W-1:0]  eff_capacity;
  logic              accept;

  // header store port
  logic              ram_we, ram_re;
  logic [GRAN_W-1:0] ram_waddr, ram_raddr;
  logic [OFF_W-1:0]  ram_rdata;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  asa_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .eff_capacity (eff_capacity)
  );

  // ---------------------------------------------------------------------------
  // Header store: saved top per header granule. Writes only come from an
  // allocate, one request ahead of any free that reads the entry, so no
  // same-cycle overlap and no forwarding is needed.
  // ---------------------------------------------------------------------------
  asa_ram #(
    .WIDTH (OFF_W),
    .DEPTH (STORE_DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshake: one request in flight; the slot must be free or draining.
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Allocate datapath
  // ---------------------------------------------------------------------------
  logic [ALIGN_W-1:0] align_m1;
  logic               align_pow2;
  logic               align_ok;
  logic [ALIGN_W-1:0] eff_align;
  logic [OFF_W:0]     eff_align_x;
  logic [OFF_W:0]     start_raw;
  logic [OFF_W:0]     start;
  logic [OFF_W+1:0]   alloc_end;
  logic               alloc_ok;

  assign align_m1   = in_alloc_alignment - ALIGN_W'(1);
  assign align_pow2 = (in_alloc_alignment != '0) && ((in_alloc_alignment & align_m1) == '0);
  assign align_ok   = align_pow2 && (in_alloc_alignment <= ALIGN_W'(MAX_ALIGN));
  assign eff_align  = (in_alloc_alignment > ALIGN_W'(HEADER_ALIGN)) ? in_alloc_alignment
                                                                    : ALIGN_W'(HEADER_ALIGN);
  assign eff_align_x = (OFF_W+1)'(eff_align);

  // round top + header up to the effective alignment
  assign start_raw = (OFF_W+1)'(top_r) + (OFF_W+1)'(HEADER_BYTES) + eff_align_x
                   - (OFF_W+1)'(1);
  assign start     = start_raw & ~(eff_align_x - (OFF_W+1)'(1));
  assign alloc_end = (OFF_W+2)'(start) + (OFF_W+2)'(in_alloc_size);

  assign alloc_ok = (in_alloc_size != '0) && align_ok && (cnt_r != COUNT_MAX)
                 && (alloc_end <= (OFF_W+2)'(eff_capacity));

  // ---------------------------------------------------------------------------
  // Free checks and granule addresses
  // ---------------------------------------------------------------------------
  logic             free_null;
  logic             free_range_ok;
  logic [OFF_W:0]   start_hdr;
  logic [OFF_W-1:0] uoff_hdr;

  assign free_null     = (in_user_offset == '0);
  assign free_range_ok = (in_user_offset >= OFF_W'(HEADER_BYTES)) && (in_user_offset <= top_r);

  assign start_hdr = start - (OFF_W+1)'(HEADER_BYTES);
  assign uoff_hdr  = in_user_offset - OFF_W'(HEADER_BYTES);
  assign ram_waddr = start_hdr[HDR_SHIFT +: GRAN_W];
  assign ram_raddr = uoff_hdr[HDR_SHIFT +: GRAN_W];

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic  done;
  stat_t res_status;
  logic [OFF_W-1:0] res_block;

  always_comb begin
    state_nxt  = state_r;
    top_nxt    = top_r;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    done       = 1'b0;
    res_status = STAT_OK;
    res_block  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req_t'(in_req_type))
            REQ_ALLOC: begin
              done = 1'b1;
              if (alloc_ok) begin
                ram_we    = 1'b1;
                top_nxt   = alloc_end[OFF_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                res_block = start[OFF_W-1:0];
              end else begin
                res_status = STAT_REFUSED;
              end
            end
            REQ_FREE: begin
              priority if (free_null) begin
                done = 1'b1;
              end else if (!free_range_ok) begin
                done       = 1'b1;
                res_status = STAT_BAD_PTR;
              end else begin
                // header lookup, finish next cycle
                ram_re    = 1'b1;
                state_nxt = S_READ;
              end
            end
            REQ_RESET: begin
              done    = 1'b1;
              top_nxt = '0;
              cnt_nxt = '0;
            end
            REQ_MARKER: begin
              done = 1'b1;
            end
            REQ_FREE_MARK: begin
              done = 1'b1;
              if (in_marker_top > top_r) begin
                res_status = STAT_AHEAD;
              end else begin
                top_nxt = in_marker_top;
                cnt_nxt = in_marker_count;
              end
            end
            default: begin
              done       = 1'b1;
              res_status = STAT_BAD_PTR;
            end
          endcase
        end
      end
      S_READ: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
        priority if (ram_rdata > top_r) begin
          res_status = STAT_AHEAD;
        end else if (cnt_r == '0) begin
          res_status = STAT_BAD_PTR;
        end else begin
          top_nxt = ram_rdata;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result slot: load on completion, else drain when taken
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_top_nxt    = out_top_r;
    out_cnt_nxt    = out_cnt_r;
    if (done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_block_nxt  = res_block;
      out_top_nxt    = top_nxt;
      out_cnt_nxt    = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_top_r    <= out_top_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_block_r;
  assign out_top_offset   = out_top_r;
  assign out_live_count   = out_cnt_r;

endmodule

// File: src/asa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module asa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/asa_cfg.sv
// APB-style register file holding capacity_bytes; exports the clamped capacity.
// Depends on asa_pkg.
module asa_cfg
  import asa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [OFF_W-1:0]      eff_capacity
);

  logic [OFF_W-1:0] capacity_r;
  logic [OFF_W-1:0] capacity_nxt;
  logic             sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[CFG_ADDR_W-1] == CFG_IDX_CAPACITY);

  always_comb begin
    capacity_nxt = capacity_r;
    if (psel && penable && pwrite && sel_cap) begin
      capacity_nxt = pwdata[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  assign prdata = sel_cap ? CFG_DATA_W'(capacity_r) : '0;

  // values above the buffer size act as the buffer size
  assign eff_capacity = (capacity_r > OFF_W'(MAX_CAPACITY)) ? OFF_W'(MAX_CAPACITY)
                                                            : capacity_r;

endmodule

// File: src/asa_checker.sv
// Port-level checks for the aligned stack allocator, bound to the top level.
// Depends on asa_pkg and aligned_stack_allocator.
module asa_checker
  import asa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [REQ_W-1:0]  in_req_type,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [OFF_W-1:0]  out_block_offset,
  input logic [OFF_W-1:0]  out_top_offset,
  input logic [CNT_W-1:0]  out_live_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_block_offset) && $stable(out_top_offset) && $stable(out_live_count))
    else $error("stalled result changed");

  // requests other than a free answer on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type != REQ_FREE) |=> out_valid)
    else $error("missing result after single-cycle request");

  // only a granted allocation carries a block offset
  a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_block_offset == '0)
    else $error("failed request with nonzero block offset");

  // a granted block lies below the new top and above its header
  a_block_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_block_offset != '0) |->
      (out_status == STAT_OK) && (out_block_offset < out_top_offset)
      && (out_block_offset >= OFF_W'(HEADER_BYTES)) && (out_live_count != '0))
    else $error("granted block inconsistent with top or count");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_block_offset (out_block_offset),
  .out_top_offset   (out_top_offset),
  .out_live_count   (out_live_count)
);
